@@ design/firfc_pkg.sv @@
// ----------------------------------------------------------------------------
// firfc_pkg
// Shared types and constants for the full-convolution FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package firfc_pkg;

  localparam int MAX_TAPS_DEFAULT = 32;
  localparam int VALUE_W          = 16;
  localparam int PROD_W           = 2 * VALUE_W;
  localparam int FILT_W           = 38;
  localparam int TIDX_W           = 5;
  localparam int TAPS_W           = 6;

  localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(32);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PUSH = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [TIDX_W-1:0]         tap_index;
    logic signed [VALUE_W-1:0] value;
    logic                      last_sample;
  } req_t;

  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic                     last_output;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic take;
  } mac_ctrl_t;

endpackage

`default_nettype wire

@@ design/firfc_mac.sv @@
// ----------------------------------------------------------------------------
// firfc_mac
// Shared multiply-accumulate unit that consumes one tap per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module firfc_mac import firfc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mac_ctrl_t                 ctrl,
  input  wire logic signed [VALUE_W-1:0] coef,
  input  wire logic signed [VALUE_W-1:0] sample,
  output logic signed [FILT_W-1:0]       acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;

  always_ff @(posedge clk) begin
    prod <= coef * sample;
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ctrl.clear) begin
      prod_valid <= 1'b0;
      acc        <= '0;
    end else begin
      prod_valid <= ctrl.take;
      if (prod_valid) begin
        acc <= acc + FILT_W'(prod);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/fir_full_convolution_top.sv @@
// ----------------------------------------------------------------------------
// fir_full_convolution_top
// Direct-form FIR filter that produces the full convolution of a signal.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload      Meaning
// req      req_valid/req_stall  req_t        coefficient load or sample push
// rsp      rsp_valid/rsp_stall  rsp_t        one convolution output
// cfg      cfg_wr_en            cfg_wr_data  filter length
//
// A coefficient load produces no output and leaves the filter ready for more.
// For each output the coefficient and delay lines rotate through the single
// multiply-accumulate unit one tap per cycle, then drain.
// A sample marked last is followed by taps-1 tail outputs, computed the same way.
// Synchronous reset clears the lines and control; the length resets to 32.
// A stalled output holds in its register; the next output waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_full_convolution_top import firfc_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rsp_t                   rsp,
  input  wire logic              cfg_wr_en,
  input  wire logic [TAPS_W-1:0] cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  typedef enum logic [1:0] {IDLE, RUN, DRAIN, DONE} state_t;

  state_t                    state;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          tail_left;
  logic                      flush;
  logic [TAPS_W-1:0]         taps_in_use;
  logic signed [VALUE_W-1:0] coef  [MAX_TAPS];
  logic signed [VALUE_W-1:0] dline [MAX_TAPS];

  logic [CNT_W-1:0]          teff;
  logic                      push_acc;
  logic                      load_acc;
  logic                      out_free;
  logic                      more_tail;
  mac_ctrl_t                 mac_ctrl;
  logic signed [FILT_W-1:0]  acc;

  always_comb begin
    if (taps_in_use == '0) begin
      teff = CNT_W'(1);
    end else if (32'(taps_in_use) > MAX_TAPS) begin
      teff = CNT_W'(MAX_TAPS);
    end else begin
      teff = CNT_W'(taps_in_use);
    end
  end

  assign req_stall = (state != IDLE);
  assign push_acc  = (state == IDLE) && req_valid && (req.mode == MODE_PUSH);
  assign load_acc  = (state == IDLE) && req_valid && (req.mode == MODE_LOAD);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign more_tail = (tail_left != '0);

  assign mac_ctrl.clear = push_acc || ((state == DONE) && out_free && more_tail);
  assign mac_ctrl.take  = (state == RUN) && (cnt < teff);

  firfc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .coef   (coef[0]),
    .sample (dline[0]),
    .acc    (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      cnt         <= '0;
      tail_left   <= '0;
      flush       <= 1'b0;
      taps_in_use <= TAPS_RESET;
      rsp_valid   <= 1'b0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        coef[i]  <= '0;
        dline[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        taps_in_use <= cfg_wr_data;
      end
      if (rsp_valid && !rsp_stall && (state != DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (load_acc) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
              if (32'(req.tap_index) == i) begin
                coef[i] <= req.value;
              end
            end
          end else if (push_acc) begin
            for (int i = 1; i < MAX_TAPS; i++) begin
              dline[i] <= dline[i-1];
            end
            dline[0]  <= req.value;
            flush     <= req.last_sample;
            tail_left <= req.last_sample ? teff - CNT_W'(1) : '0;
            cnt       <= '0;
            state     <= RUN;
          end
        end
        RUN: begin
          for (int i = 0; i < MAX_TAPS - 1; i++) begin
            coef[i]  <= coef[i+1];
            dline[i] <= dline[i+1];
          end
          coef[MAX_TAPS-1]  <= coef[0];
          dline[MAX_TAPS-1] <= dline[0];
          cnt               <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MAX_TAPS - 1)) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= DONE;
        end
        DONE: begin
          if (out_free) begin
            rsp.filtered    <= acc;
            rsp.last_output <= flush && !more_tail;
            rsp_valid       <= 1'b1;
            if (more_tail) begin
              for (int i = 1; i < MAX_TAPS; i++) begin
                dline[i] <= dline[i-1];
              end
              dline[0]  <= '0;
              tail_left <= tail_left - CNT_W'(1);
              cnt       <= '0;
              state     <= RUN;
            end else begin
              if (flush) begin
                for (int i = 0; i < MAX_TAPS; i++) begin
                  dline[i] <= '0;
                end
              end
              flush <= 1'b0;
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/firfc_checker.sv @@
// ----------------------------------------------------------------------------
// firfc_checker
// Port-level checks for the full-convolution FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

module firfc_checker import firfc_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire req_t req,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  logic req_take;
  logic rsp_take;

  assign req_take = req_valid && !req_stall;
  assign rsp_take = rsp_valid && !rsp_stall;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("Stalled output transaction changed or vanished.");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    req_take && (req.mode == MODE_LOAD) && !rsp_valid |=> !rsp_valid)
    else $error("Coefficient load produced an output transaction.");

  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    req_take && (req.mode == MODE_PUSH) |=> req_stall)
    else $error("Sample push did not occupy the filter.");

  a_last_single: assert property (@(posedge clk) disable iff (rst)
    rsp_take && rsp.last_output |=> !(rsp_valid && rsp.last_output))
    else $error("Two final outputs in consecutive cycles.");

endmodule

bind fir_full_convolution_top firfc_checker u_firfc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the full-convolution FIR filter. A driver sends
// coefficient loads and sample pushes from a queue of pending requests. A
// monitor compares every output with a software copy of the filter that
// tracks the coefficients, the delay line and the filter length. Phases
// change the length and the amount of idling and stalling on both channels.
// ----------------------------------------------------------------------------
module tb import firfc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TAPS       = MAX_TAPS_DEFAULT;
  localparam int SETTLE_CYCLES  = 2 * (MAX_TAPS + 2) + 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int ITEMS_END      = 430;
  localparam int MAX_REPORTS    = 50;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_t              req_item = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp_item;
  logic              cfg_wr_en = 1'b0;
  logic [TAPS_W-1:0] cfg_wr_data = '0;

  req_t pending_requests[$];
  rsp_t expected_outputs[$];

  logic signed [VALUE_W-1:0] coef_mem [MAX_TAPS] = '{default: '0};
  logic signed [VALUE_W-1:0] line_mem [MAX_TAPS] = '{default: '0};
  logic [TAPS_W-1:0]         taps_reg = TAPS_RESET;

  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  bit   hold_armed = 1'b0;
  int   hold_left = 0;
  int   error_count = 0;
  int   queued_items = 0;
  int   quiet_cycles = 0;
  logic fire;
  rsp_t want;

  fir_full_convolution_top #(.MAX_TAPS(MAX_TAPS)) DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req_item),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int active_len();
    int t;
    t = int'(taps_reg);
    if (t == 0) t = 1;
    if (t > MAX_TAPS) t = MAX_TAPS;
    return t;
  endfunction

  function automatic logic signed [FILT_W-1:0] tap_sum();
    logic signed [63:0] acc;
    int k;
    acc = '0;
    for (k = 0; k < active_len(); k++) begin
      acc = acc + 64'(coef_mem[k]) * 64'(line_mem[k]);
    end
    return acc[FILT_W-1:0];
  endfunction

  task automatic shift_line(input logic signed [VALUE_W-1:0] sample);
    int k;
    for (k = MAX_TAPS - 1; k > 0; k--) line_mem[k] = line_mem[k-1];
    line_mem[0] = sample;
  endtask

  task automatic apply_transaction(input req_t r);
    int   taps;
    int   t;
    rsp_t o;
    taps = active_len();
    if (r.mode == MODE_LOAD) begin
      if (int'(r.tap_index) < MAX_TAPS) coef_mem[r.tap_index] = r.value;
    end else begin
      shift_line(r.value);
      o.filtered = tap_sum();
      o.last_output = r.last_sample && (taps == 1);
      expected_outputs.push_back(o);
      if (r.last_sample) begin
        for (t = 1; t < taps; t++) begin
          shift_line('0);
          o.filtered = tap_sum();
          o.last_output = (t == taps - 1);
          expected_outputs.push_back(o);
        end
        line_mem = '{default: '0};
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      fire = req_valid && !req_stall;
      if (fire) apply_transaction(req_item);
      if (!req_valid || fire) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          req_item <= pending_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_outputs.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected output, expected none, got filtered %0d last %0b",
                   $time, rsp_item.filtered, rsp_item.last_output);
      end else begin
        want = expected_outputs.pop_front();
        if (rsp_item.filtered !== want.filtered) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: filtered mismatch, expected %0d, got %0d",
                     $time, want.filtered, rsp_item.filtered);
        end
        if (rsp_item.last_output !== want.last_output) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: last_output mismatch, expected %0b, got %0b",
                     $time, want.last_output, rsp_item.last_output);
        end
      end
    end
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [TAPS_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 50) return TAPS_W'($urandom_range(1, 6));
    if (r < 75) return TAPS_W'($urandom_range(7, MAX_TAPS));
    if (r < 82) return '0;
    if (r < 90) return TAPS_W'(MAX_TAPS);
    return TAPS_W'($urandom_range(MAX_TAPS + 1, 63));
  endfunction

  task automatic enqueue(input logic mode, input int idx, input logic signed [VALUE_W-1:0] val,
                         input logic last);
    req_t r;
    r.mode = mode;
    r.tap_index = idx[TIDX_W-1:0];
    r.value = val;
    r.last_sample = last;
    pending_requests.push_back(r);
    queued_items++;
  endtask

  task automatic add_signal(input int len, input bit closed);
    int k;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0)
        enqueue(MODE_LOAD, $urandom_range(31), pick_value(), 1'($urandom_range(1)));
      enqueue(MODE_PUSH, $urandom_range(31), pick_value(), closed && (k == len - 1));
    end
  endtask

  task automatic set_idle(input int kind);
    case (kind)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
      default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
    endcase
  endtask

  task automatic drain_all();
    while (pending_requests.size() != 0 || req_valid || expected_outputs.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(input logic [TAPS_W-1:0] len);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    taps_reg = len;
    @(negedge clk);
  endtask

  initial begin
    int phase_no;
    int phase_start;
    int k;
    logic [TAPS_W-1:0] len_sel;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    enqueue(MODE_LOAD, 0, 16'sh7FFF, 1'b0);
    enqueue(MODE_LOAD, 31, 16'sh8000, 1'b0);
    enqueue(MODE_LOAD, 1, 16'shFFFF, 1'b1);
    enqueue(MODE_LOAD, 30, 16'sh0001, 1'b0);
    enqueue(MODE_LOAD, 2, 16'sh8000, 1'b0);
    enqueue(MODE_PUSH, 0, 16'sh7FFF, 1'b0);
    enqueue(MODE_PUSH, 31, 16'sh8000, 1'b0);
    enqueue(MODE_PUSH, 21, 16'sh0000, 1'b1);
    drain_all();

    write_length(TAPS_W'(1));
    enqueue(MODE_PUSH, 0, 16'sh8000, 1'b1);
    enqueue(MODE_PUSH, 0, 16'sh7FFF, 1'b0);
    enqueue(MODE_PUSH, 10, 16'sh0001, 1'b1);
    drain_all();

    write_length('0);
    enqueue(MODE_PUSH, 5, 16'shFFFF, 1'b1);
    drain_all();

    write_length(TAPS_W'(63));
    enqueue(MODE_PUSH, 0, 16'sh3039, 1'b0);
    enqueue(MODE_PUSH, 0, 16'sh8000, 1'b1);
    drain_all();

    write_length(TAPS_W'(4));
    enqueue(MODE_PUSH, 0, 16'sh0064, 1'b0);
    enqueue(MODE_PUSH, 0, -16'sd200, 1'b0);
    enqueue(MODE_PUSH, 0, 16'sh012C, 1'b0);
    drain_all();

    write_length(TAPS_W'(20));
    enqueue(MODE_PUSH, 0, 16'sh8000, 1'b1);
    drain_all();

    phase_no = 0;
    while (queued_items < ITEMS_END) begin
      set_idle(phase_no % 4);
      len_sel = (phase_no == 1) ? TAPS_W'(MAX_TAPS) : pick_length();
      write_length(len_sel);
      phase_start = queued_items;
      if (phase_no == 1) begin
        for (k = 0; k < MAX_TAPS; k++) enqueue(MODE_LOAD, k, 16'sh8000, 1'b0);
        for (k = 0; k < 3; k++) enqueue(MODE_PUSH, k, 16'sh8000, k == 2);
      end else begin
        if (phase_no == 2) begin
          set_idle(0);
          hold_armed = 1'b1;
        end
        repeat ($urandom_range(1, 6))
          enqueue(MODE_LOAD, $urandom_range(31), pick_value(), 1'($urandom_range(1)));
        while (queued_items - phase_start < 36) add_signal($urandom_range(1, 6), 1'b1);
        if ($urandom_range(3) == 0) add_signal($urandom_range(1, 3), 1'b0);
      end
      drain_all();
      phase_no++;
    end

    if (error_count == 0 && expected_outputs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/firfc_pkg.sv
design/firfc_mac.sv
design/fir_full_convolution_top.sv
design/firfc_checker.sv
tb/tb.sv
